// ----- rtl/assert_macros.svh -----
// Assertion macros for the checker file of this block.
// No dependencies.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Concurrent assertion on a named clock and active-low reset.
`define HRC_ASSERT_CLK(lbl, clk, rstn, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) prop) \
    else $error("hrc assertion failed");

// Same, on the block's own clock and reset.
`define HRC_ASSERT(lbl, prop) `HRC_ASSERT_CLK(lbl, clk_i, rst_ni, prop)

`endif

// ----- rtl/hrc_pkg.sv -----
// Package of the harmonic resonator controller: types, constants, helpers.
// No dependencies.
`timescale 1ns / 1ps

package hrc_pkg;

  localparam int SAMPLE_W   = 24;
  localparam int COEF_W     = 18;
  localparam int PHASOR_W   = 19;   // one more bit so that 1.0 fits
  localparam int STATE_W    = 32;
  localparam int PSTEP_W    = 24;
  localparam int ALPHA_W    = 16;
  localparam int IDX_W      = 4;
  localparam int AE_W       = 33;
  localparam int MUL_W      = 34;
  localparam int PROD_W     = 68;
  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = 24;

  typedef logic signed [MUL_W-1:0]  mop_t;
  typedef logic signed [PROD_W-1:0] wide_t;

  // Register indexes
  localparam logic [CFG_IDX_W-1:0] REG_PHASE_STEP = 1'd0;
  localparam logic [CFG_IDX_W-1:0] REG_STEP_SIZE  = 1'd1;

  localparam logic [PSTEP_W-1:0] PSTEP_RST = 24'd17476;
  localparam logic [ALPHA_W-1:0] ALPHA_RST = 16'd655;

  // 1.0 in Q1.17 and the largest phasor part
  localparam logic signed [PHASOR_W-1:0] PHASOR_ONE = 19'sd131072;
  localparam wide_t TRIG_MAX = 68'sd131071;

  // Odd Taylor coefficients of sin(pi/2*u), Q30
  localparam wide_t Q30_C1 = 68'sd1686629713;
  localparam wide_t Q30_C3 = 68'sd693598670;
  localparam wide_t Q30_C5 = 68'sd85569306;
  localparam wide_t Q30_C7 = 68'sd5026995;
  localparam wide_t Q30_C9 = 68'sd172272;

  typedef enum logic [3:0] {
    OP_NONE, OP_SAMPLE, OP_COEF, OP_TRIG_SQ, OP_TRIG_HORN, OP_TRIG_FIN,
    OP_CSEL, OP_CREC, OP_ACC, OP_ERR, OP_AE, OP_BX, OP_UPD
  } op_e;

  typedef enum logic [3:0] {
    ST_IDLE, ST_TRIG_SQ, ST_TRIG_HORN, ST_TRIG_FIN, ST_CSEL, ST_CREC,
    ST_ACC, ST_ERR, ST_AE, ST_BX, ST_UPD, ST_DONE
  } state_e;

  // Command from the sequencer: issue loads the products, wb writes back
  typedef struct packed {
    op_e        op;
    logic       issue;
    logic       wb;
    logic [1:0] hstep;
  } dp_cmd_t;

  // Horner coefficient for step h, highest order first
  function automatic wide_t horner_coef(logic [1:0] h);
    wide_t c;
    case (h)
      2'd0:    c = Q30_C7;
      2'd1:    c = Q30_C5;
      2'd2:    c = Q30_C3;
      default: c = Q30_C1;
    endcase
    return c;
  endfunction

  // Shift right by n, rounding half up
  function automatic wide_t rnd_shr(wide_t v, int unsigned n);
    wide_t half;
    half = wide_t'(1) <<< (n - 1);
    return (v + half) >>> n;
  endfunction

  // Saturate to a signed w-bit range
  function automatic wide_t sat(wide_t v, int unsigned w);
    wide_t hi;
    wide_t lo;
    hi = (wide_t'(1) <<< (w - 1)) - wide_t'(1);
    lo = -hi - wide_t'(1);
    return (v > hi) ? hi : ((v < lo) ? lo : v);
  endfunction

endpackage

// ----- rtl/hrc_if.sv -----
// Valid/ready channel interfaces for sample/coefficient items and results.
// Depends on hrc_pkg.
`timescale 1ns / 1ps

interface hrc_in_if import hrc_pkg::*; ();
  logic                       valid;
  logic                       ready;
  logic                       req_type;
  logic signed [SAMPLE_W-1:0] sample;
  logic [IDX_W-1:0]           coef_index;
  logic signed [COEF_W-1:0]   coef_real;
  logic signed [COEF_W-1:0]   coef_imag;

  modport source (output valid, req_type, sample, coef_index, coef_real, coef_imag,
                  input ready);
  modport sink   (input valid, req_type, sample, coef_index, coef_real, coef_imag,
                  output ready);
endinterface

interface hrc_out_if import hrc_pkg::*; ();
  logic                       valid;
  logic                       ready;
  logic signed [SAMPLE_W-1:0] control_out;

  modport source (output valid, control_out, input ready);
  modport sink   (input valid, control_out, output ready);
endinterface

// ----- rtl/hrc_ctrl.sv -----
// Sequencer of the harmonic resonator controller: steps the datapath through
// the sine/cosine, estimate and update passes. Depends on hrc_pkg.
`timescale 1ns / 1ps

module hrc_ctrl import hrc_pkg::*; #(
  parameter int HARMONICS = 16
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         in_valid_i,
  input  logic                         in_req_type_i,
  output logic                         in_ready_o,
  input  logic                         out_free_i,
  output logic                         out_load_o,
  output dp_cmd_t                      cmd_o,
  output logic [$clog2(HARMONICS)-1:0] k_o
);

  localparam int KW = $clog2(HARMONICS);
  localparam logic [KW-1:0] KLAST = KW'(HARMONICS - 1);

  state_e        state_q, state_d;
  logic          half_q, half_d;
  logic [KW-1:0] k_q, k_d;
  logic [1:0]    h_q, h_d;
  logic          mult_st;

  // States that issue multiplier products and then write them back
  always_comb begin
    unique case (state_q)
      ST_TRIG_SQ, ST_TRIG_HORN, ST_TRIG_FIN, ST_CREC, ST_ACC, ST_AE, ST_BX,
      ST_UPD:  mult_st = 1'b1;
      default: mult_st = 1'b0;
    endcase
  end

  // Next state
  always_comb begin
    state_d = state_q;
    k_d     = k_q;
    h_d     = h_q;
    half_d  = mult_st ? !half_q : 1'b0;
    unique case (state_q)
      ST_IDLE: begin
        if (in_valid_i && !in_req_type_i) begin
          state_d = ST_TRIG_SQ;
        end
      end
      ST_TRIG_SQ: begin
        if (half_q) begin
          state_d = ST_TRIG_HORN;
          h_d     = 2'd0;
        end
      end
      ST_TRIG_HORN: begin
        if (half_q) begin
          if (h_q == 2'd3) begin
            state_d = ST_TRIG_FIN;
          end else begin
            h_d = h_q + 2'd1;
          end
        end
      end
      ST_TRIG_FIN: begin
        if (half_q) begin
          state_d = ST_CSEL;
          k_d     = '0;
        end
      end
      ST_CSEL: state_d = ST_ACC;
      ST_CREC: begin
        if (half_q) begin
          state_d = ST_ACC;
        end
      end
      ST_ACC: begin
        if (half_q) begin
          if (k_q == KLAST) begin
            state_d = ST_ERR;
            k_d     = '0;
          end else begin
            k_d     = k_q + KW'(1);
            state_d = (k_q == '0) ? ST_CSEL : ST_CREC;
          end
        end
      end
      ST_ERR: state_d = ST_AE;
      ST_AE: begin
        if (half_q) begin
          state_d = ST_BX;
        end
      end
      ST_BX: begin
        if (half_q) begin
          state_d = ST_UPD;
        end
      end
      ST_UPD: begin
        if (half_q) begin
          if (k_q == KLAST) begin
            state_d = ST_DONE;
          end else begin
            k_d     = k_q + KW'(1);
            state_d = ST_BX;
          end
        end
      end
      ST_DONE: begin
        if (out_free_i) begin
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  // Commands and handshake
  always_comb begin
    cmd_o.op    = OP_NONE;
    cmd_o.issue = mult_st && !half_q;
    cmd_o.wb    = mult_st && half_q;
    cmd_o.hstep = h_q;
    in_ready_o  = 1'b0;
    out_load_o  = 1'b0;
    unique case (state_q)
      ST_IDLE: begin
        in_ready_o = 1'b1;
        cmd_o.op   = in_req_type_i ? OP_COEF : OP_SAMPLE;
        cmd_o.wb   = in_valid_i;
      end
      ST_TRIG_SQ:   cmd_o.op = OP_TRIG_SQ;
      ST_TRIG_HORN: cmd_o.op = OP_TRIG_HORN;
      ST_TRIG_FIN:  cmd_o.op = OP_TRIG_FIN;
      ST_CSEL: begin
        cmd_o.op = OP_CSEL;
        cmd_o.wb = 1'b1;
      end
      ST_CREC: cmd_o.op = OP_CREC;
      ST_ACC:  cmd_o.op = OP_ACC;
      ST_ERR: begin
        cmd_o.op = OP_ERR;
        cmd_o.wb = 1'b1;
      end
      ST_AE:   cmd_o.op = OP_AE;
      ST_BX:   cmd_o.op = OP_BX;
      ST_UPD:  cmd_o.op = OP_UPD;
      ST_DONE: out_load_o = out_free_i;
      default: cmd_o.op = OP_NONE;
    endcase
  end

  assign k_o = k_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      half_q  <= 1'b0;
      k_q     <= '0;
      h_q     <= '0;
    end else begin
      state_q <= state_d;
      half_q  <= half_d;
      k_q     <= k_d;
      h_q     <= h_d;
    end
  end

endmodule

// ----- rtl/hrc_dp.sv -----
// Datapath of the harmonic resonator controller: state stores, four shared
// multipliers and the write-back arithmetic. Depends on hrc_pkg.
`timescale 1ns / 1ps

module hrc_dp import hrc_pkg::*; #(
  parameter int HARMONICS  = 16,
  parameter int PHASE_BITS = 24
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  dp_cmd_t                      cmd_i,
  input  logic [$clog2(HARMONICS)-1:0] k_i,
  input  logic signed [SAMPLE_W-1:0]   sample_i,
  input  logic [IDX_W-1:0]             coef_index_i,
  input  logic signed [COEF_W-1:0]     coef_real_i,
  input  logic signed [COEF_W-1:0]     coef_imag_i,
  input  logic                         cfg_we_i,
  input  logic [CFG_IDX_W-1:0]         cfg_idx_i,
  input  logic [CFG_DATA_W-1:0]        cfg_data_i,
  output logic signed [SAMPLE_W-1:0]   result_o
);

  localparam int KW = $clog2(HARMONICS);

  // Configuration and state stores
  logic [PSTEP_W-1:0]           phase_step_q;
  logic [ALPHA_W-1:0]           step_size_q;
  logic [PHASE_BITS-1:0]        phase_acc_q;
  logic signed [STATE_W-1:0]    est_re_q [HARMONICS];
  logic signed [STATE_W-1:0]    est_im_q [HARMONICS];
  logic signed [STATE_W-1:0]    ctl_re_q [HARMONICS];
  logic signed [STATE_W-1:0]    ctl_im_q [HARMONICS];
  logic signed [COEF_W-1:0]     beta_re_q [HARMONICS];
  logic signed [COEF_W-1:0]     beta_im_q [HARMONICS];

  // Per-sample working registers
  logic signed [PHASOR_W-1:0]   c_re_q [HARMONICS];
  logic signed [PHASOR_W-1:0]   c_im_q [HARMONICS];
  logic signed [PHASOR_W-1:0]   c1_re_q, c1_im_q, cc_re_q, cc_im_q;
  logic signed [STATE_W-1:0]    x2_q [2];
  logic signed [STATE_W-1:0]    tt_q [2];
  logic signed [SAMPLE_W-1:0]   sample_q;
  wide_t                        yacc_q, racc_q;
  logic signed [STATE_W-1:0]    e_q;
  logic signed [AE_W-1:0]       ae_q;
  logic signed [SAMPLE_W-1:0]   result_q;
  wide_t                        prod_q [4];

  logic [15:0]                  ang_sin, ang_cos;
  logic [14:0]                  q_sin, q_cos;
  logic [30:0]                  x_sin, x_cos;
  mop_t                         opa [4];
  mop_t                         opb [4];
  logic signed [STATE_W-1:0]    xr, xi, pr, pi_v;
  logic signed [COEF_W-1:0]     br, bi;
  wide_t                        sfin [2];
  wide_t                        crec_re, crec_im, dy, dr, y_val, e_val, res_val;
  wide_t                        ctl_re_new, ctl_im_new, est_re_new, est_im_new;
  logic [31:0]                  cidx;

  // Top 16 bits of the phase as the angle, zero-filled below if narrower
  if (PHASE_BITS >= 16) begin : g_ang_hi
    assign ang_sin = phase_acc_q[PHASE_BITS-1 -: 16];
  end else begin : g_ang_lo
    assign ang_sin = {phase_acc_q, {(16 - PHASE_BITS){1'b0}}};
  end
  assign ang_cos = ang_sin + 16'h4000;

  // Quarter-wave folding
  assign q_sin = ang_sin[14] ? (15'd16384 - {1'b0, ang_sin[13:0]}) : {1'b0, ang_sin[13:0]};
  assign q_cos = ang_cos[14] ? (15'd16384 - {1'b0, ang_cos[13:0]}) : {1'b0, ang_cos[13:0]};
  assign x_sin = {q_sin, 16'b0};
  assign x_cos = {q_cos, 16'b0};

  assign xr   = est_re_q[k_i];
  assign xi   = est_im_q[k_i];
  assign pr   = ctl_re_q[k_i];
  assign pi_v = ctl_im_q[k_i];
  assign br   = beta_re_q[k_i];
  assign bi   = beta_im_q[k_i];

  // Multiplier operand selection
  always_comb begin
    for (int i = 0; i < 4; i++) begin
      opa[i] = '0;
      opb[i] = '0;
    end
    case (cmd_i.op)
      OP_TRIG_SQ: begin
        opa[0] = MUL_W'(x_sin);  opb[0] = MUL_W'(x_sin);
        opa[1] = MUL_W'(x_cos);  opb[1] = MUL_W'(x_cos);
      end
      OP_TRIG_HORN: begin
        opa[0] = MUL_W'(tt_q[0]); opb[0] = MUL_W'(x2_q[0]);
        opa[1] = MUL_W'(tt_q[1]); opb[1] = MUL_W'(x2_q[1]);
      end
      OP_TRIG_FIN: begin
        opa[0] = MUL_W'(tt_q[0]); opb[0] = MUL_W'(x_sin);
        opa[1] = MUL_W'(tt_q[1]); opb[1] = MUL_W'(x_cos);
      end
      OP_CREC: begin
        opa[0] = MUL_W'(c1_re_q); opb[0] = MUL_W'(cc_re_q);
        opa[1] = MUL_W'(c1_im_q); opb[1] = MUL_W'(cc_im_q);
        opa[2] = MUL_W'(c1_re_q); opb[2] = MUL_W'(cc_im_q);
        opa[3] = MUL_W'(c1_im_q); opb[3] = MUL_W'(cc_re_q);
      end
      OP_ACC: begin
        opa[0] = MUL_W'(cc_re_q); opb[0] = MUL_W'(xr);
        opa[1] = MUL_W'(cc_im_q); opb[1] = MUL_W'(xi);
        opa[2] = MUL_W'(cc_re_q); opb[2] = MUL_W'(pr);
        opa[3] = MUL_W'(cc_im_q); opb[3] = MUL_W'(pi_v);
      end
      OP_AE: begin
        opa[0] = MUL_W'(step_size_q); opb[0] = MUL_W'(e_q);
      end
      OP_BX: begin
        opa[0] = MUL_W'(br); opb[0] = MUL_W'(xr);
        opa[1] = MUL_W'(bi); opb[1] = MUL_W'(xi);
        opa[2] = MUL_W'(br); opb[2] = MUL_W'(xi);
        opa[3] = MUL_W'(bi); opb[3] = MUL_W'(xr);
      end
      OP_UPD: begin
        opa[0] = MUL_W'(ae_q); opb[0] = MUL_W'(c_re_q[k_i]);
        opa[1] = MUL_W'(ae_q); opb[1] = MUL_W'(c_im_q[k_i]);
      end
      default: ;
    endcase
  end

  // Write-back arithmetic
  always_comb begin
    for (int i = 0; i < 2; i++) begin
      sfin[i] = rnd_shr(prod_q[i], 43);
      if (sfin[i] > TRIG_MAX) begin
        sfin[i] = TRIG_MAX;
      end
    end
    if (ang_sin[15]) begin
      sfin[0] = -sfin[0];
    end
    if (ang_cos[15]) begin
      sfin[1] = -sfin[1];
    end
    crec_re    = sat(rnd_shr(prod_q[0] - prod_q[1], 17), COEF_W);
    crec_im    = sat(rnd_shr(prod_q[2] + prod_q[3], 17), COEF_W);
    dy         = prod_q[0] - prod_q[1];
    dr         = prod_q[2] - prod_q[3];
    y_val      = sat(rnd_shr(yacc_q, 17), STATE_W);
    e_val      = sat((wide_t'(sample_q) <<< 1) - y_val, STATE_W);
    res_val    = sat(rnd_shr(-racc_q, 18), SAMPLE_W);
    ctl_re_new = sat(wide_t'(pr) + rnd_shr(prod_q[0] - prod_q[1], 17), STATE_W);
    ctl_im_new = sat(wide_t'(pi_v) + rnd_shr(prod_q[2] + prod_q[3], 17), STATE_W);
    est_re_new = sat(wide_t'(xr) + rnd_shr(prod_q[0], 17), STATE_W);
    est_im_new = sat(wide_t'(xi) - rnd_shr(prod_q[1], 17), STATE_W);
  end

  assign cidx = 32'(coef_index_i);

  // Products: registered at issue
  always_ff @(posedge clk_i) begin
    if (cmd_i.issue) begin
      for (int i = 0; i < 4; i++) begin
        prod_q[i] <= opa[i] * opb[i];
      end
    end
  end

  // Working registers
  always_ff @(posedge clk_i) begin
    if (cmd_i.wb) begin
      case (cmd_i.op)
        OP_SAMPLE: begin
          sample_q <= sample_i;
          yacc_q   <= '0;
          racc_q   <= '0;
        end
        OP_TRIG_SQ: begin
          for (int i = 0; i < 2; i++) begin
            x2_q[i] <= STATE_W'(prod_q[i] >>> 30);
            tt_q[i] <= STATE_W'(Q30_C9);
          end
        end
        OP_TRIG_HORN: begin
          for (int i = 0; i < 2; i++) begin
            tt_q[i] <= STATE_W'(horner_coef(cmd_i.hstep) - (prod_q[i] >>> 30));
          end
        end
        OP_TRIG_FIN: begin
          c1_im_q <= PHASOR_W'(sfin[0]);
          c1_re_q <= PHASOR_W'(sfin[1]);
        end
        OP_CSEL: begin
          if (k_i == '0) begin
            cc_re_q <= PHASOR_ONE;
            cc_im_q <= '0;
          end else begin
            cc_re_q <= c1_re_q;
            cc_im_q <= c1_im_q;
          end
        end
        OP_CREC: begin
          cc_re_q <= PHASOR_W'(crec_re);
          cc_im_q <= PHASOR_W'(crec_im);
        end
        OP_ACC: begin
          c_re_q[k_i] <= cc_re_q;
          c_im_q[k_i] <= cc_im_q;
          // the constant term is counted once, harmonics twice
          yacc_q <= yacc_q + ((k_i == '0) ? dy : (dy <<< 1));
          racc_q <= racc_q + ((k_i == '0) ? dr : (dr <<< 1));
        end
        OP_ERR: e_q <= STATE_W'(e_val);
        OP_AE: begin
          ae_q     <= AE_W'(rnd_shr(prod_q[0], 16));
          result_q <= SAMPLE_W'(res_val);
        end
        default: ;
      endcase
    end
  end

  // Configuration and state stores
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_step_q <= PSTEP_RST;
      step_size_q  <= ALPHA_RST;
      phase_acc_q  <= '0;
      for (int i = 0; i < HARMONICS; i++) begin
        est_re_q[i]  <= '0;
        est_im_q[i]  <= '0;
        ctl_re_q[i]  <= '0;
        ctl_im_q[i]  <= '0;
        beta_re_q[i] <= '0;
        beta_im_q[i] <= '0;
      end
    end else begin
      if (cfg_we_i) begin
        unique case (cfg_idx_i)
          REG_PHASE_STEP: phase_step_q <= PSTEP_W'(cfg_data_i);
          REG_STEP_SIZE:  step_size_q  <= ALPHA_W'(cfg_data_i);
          default: ;
        endcase
      end
      if (cmd_i.wb) begin
        case (cmd_i.op)
          OP_COEF: begin
            if (cidx < 32'(HARMONICS)) begin
              beta_re_q[cidx[KW-1:0]] <= coef_real_i;
              beta_im_q[cidx[KW-1:0]] <= coef_imag_i;
            end
          end
          OP_ERR: phase_acc_q <= phase_acc_q + PHASE_BITS'(phase_step_q);
          OP_BX: begin
            // the fundamental is left uncontrolled
            if (k_i == KW'(1)) begin
              ctl_re_q[k_i] <= '0;
              ctl_im_q[k_i] <= '0;
            end else begin
              ctl_re_q[k_i] <= STATE_W'(ctl_re_new);
              ctl_im_q[k_i] <= STATE_W'(ctl_im_new);
            end
          end
          OP_UPD: begin
            est_re_q[k_i] <= STATE_W'(est_re_new);
            est_im_q[k_i] <= STATE_W'(est_im_new);
          end
          default: ;
        endcase
      end
    end
  end

  assign result_o = result_q;

endmodule

// ----- rtl/harmonic_resonator_controller.sv -----
// Harmonic resonator controller: input channel takes audio samples
// (req_type 0) and beta coefficient writes (req_type 1); output channel
// gives the negated, saturated control value, one per audio sample.
// A coefficient item is written as it is taken and gives no result.
// An audio sample occupies the block while the sequencer runs complex
// products on four shared multipliers, over a phasor/estimate pass and
// an update pass through all harmonics, before its result is loaded into
// the output register. Input ready is high only while idle.
// The finished result sits in an output register, so a new item is taken
// while it waits; a sample that finishes while the receiver still stalls
// holds in its last state until the register frees.
// phase_step and step_size are written through the cfg port, one register
// per cycle, by the user only while idle; the block does not enforce it.
// Reset clears phase, estimator, control and coefficient stores at once;
// no clearing pass is needed.
// Depends on hrc_pkg, hrc_if, hrc_ctrl and hrc_dp.
`timescale 1ns / 1ps

module harmonic_resonator_controller import hrc_pkg::*; #(
  parameter int HARMONICS  = 16,
  parameter int PHASE_BITS = 24
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  hrc_in_if.sink                in_if,
  hrc_out_if.source             out_if,
  input  logic                  cfg_we_i,
  input  logic [CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [CFG_DATA_W-1:0] cfg_data_i
);

  localparam int KW = $clog2(HARMONICS);

  dp_cmd_t                    cmd;
  logic [KW-1:0]              k;
  logic                       out_free, out_load;
  logic signed [SAMPLE_W-1:0] result;
  logic                       out_valid_q;
  logic signed [SAMPLE_W-1:0] out_data_q;

  hrc_ctrl #(.HARMONICS(HARMONICS)) u_ctrl (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (in_if.valid),
    .in_req_type_i (in_if.req_type),
    .in_ready_o    (in_if.ready),
    .out_free_i    (out_free),
    .out_load_o    (out_load),
    .cmd_o         (cmd),
    .k_o           (k)
  );

  hrc_dp #(.HARMONICS(HARMONICS), .PHASE_BITS(PHASE_BITS)) u_dp (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cmd_i        (cmd),
    .k_i          (k),
    .sample_i     (in_if.sample),
    .coef_index_i (in_if.coef_index),
    .coef_real_i  (in_if.coef_real),
    .coef_imag_i  (in_if.coef_imag),
    .cfg_we_i     (cfg_we_i),
    .cfg_idx_i    (cfg_idx_i),
    .cfg_data_i   (cfg_data_i),
    .result_o     (result)
  );

  // Output register
  assign out_free = !out_valid_q || out_if.ready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (out_load) begin
      out_valid_q <= 1'b1;
    end else if (out_if.ready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_load) begin
      out_data_q <= result;
    end
  end

  assign out_if.valid       = out_valid_q;
  assign out_if.control_out = out_data_q;

endmodule

// ----- rtl/hrc_checker.sv -----
// Port-level checks for the harmonic resonator controller, bound to the top.
// Depends on assert_macros.svh.
`timescale 1ns / 1ps
`include "assert_macros.svh"

module hrc_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        in_valid_i,
  input logic        in_ready_i,
  input logic        in_req_type_i,
  input logic        out_valid_i,
  input logic        out_ready_i,
  input logic [23:0] control_out_i
);

  // A stalled result stays offered
  `HRC_ASSERT(a_out_hold, out_valid_i && !out_ready_i |=> out_valid_i)

  // A stalled result keeps its value
  `HRC_ASSERT(a_out_stable, out_valid_i && !out_ready_i |=> $stable(control_out_i))

  // An audio sample keeps input ready low after it is taken
  `HRC_ASSERT(a_sample_busy, in_valid_i && in_ready_i && !in_req_type_i |=> !in_ready_i ##1 !in_ready_i)

  // A coefficient write produces no result
  `HRC_ASSERT(a_coef_silent, in_valid_i && in_ready_i && in_req_type_i && !out_valid_i |=> !out_valid_i)

endmodule

bind harmonic_resonator_controller hrc_checker u_hrc_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .in_valid_i    (in_if.valid),
  .in_ready_i    (in_if.ready),
  .in_req_type_i (in_if.req_type),
  .out_valid_i   (out_if.valid),
  .out_ready_i   (out_if.ready),
  .control_out_i (out_if.control_out)
);
